// ===== rtl/core/sme_pkg.sv =====
// ----------------------------------------------------------------------------
// sme_pkg
// Shared types and constants for the stack machine execution unit: word and
// address widths, opcode and error codes, controller states, and the command
// and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package sme_pkg;

   // Word, program and variable file geometry
   localparam int WORD_W              = 32;
   localparam int PROGRAM_DEPTH       = 4096;
   localparam int IP_W                = $clog2(PROGRAM_DEPTH);
   localparam int VAR_COUNT           = 16;
   localparam int VAR_IDX_W           = $clog2(VAR_COUNT);
   localparam int STACK_DEPTH_DEFAULT = 64;

   typedef logic [WORD_W-1:0] word_type;

   // Instruction opcodes; codes above OP_JF are no-ops
   typedef enum logic [4:0] {
      OP_HALT    = 5'd0,
      OP_CONST   = 5'd1,
      OP_POPVAR  = 5'd2,
      OP_PUSHVAR = 5'd3,
      OP_READ    = 5'd4,
      OP_WRITE   = 5'd5,
      OP_ADD     = 5'd6,
      OP_SUB     = 5'd7,
      OP_MUL     = 5'd8,
      OP_DIV     = 5'd9,
      OP_MOD     = 5'd10,
      OP_EQ      = 5'd11,
      OP_NE      = 5'd12,
      OP_LT      = 5'd13,
      OP_LE      = 5'd14,
      OP_GT      = 5'd15,
      OP_GE      = 5'd16,
      OP_OR      = 5'd17,
      OP_AND     = 5'd18,
      OP_JMP     = 5'd19,
      OP_JT      = 5'd20,
      OP_JF      = 5'd21
   } op_type;

   // Runtime error codes
   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_UNDERFLOW = 2'd1,
      ERR_DIVZERO   = 2'd2,
      ERR_OVERFLOW  = 2'd3
   } err_type;

   // Controller states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_POPB,
      S_POPA,
      S_EXEC,
      S_DIV,
      S_PUSH,
      S_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic start;      // latch the incoming transaction
      logic pop;        // pop one word from the stack
      logic cap_b;      // capture the popped word as operand b
      logic cap_a;      // capture the popped word as operand a
      logic exec;       // execute the instruction
      logic div_start;  // launch the divider
      logic div_cap;    // take the divider result
      logic push;       // push the result word
      logic finish;     // commit the pointer and load the response
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic       running;
      logic [1:0] pop_count;
      logic       needs_push;
      logic       div_op;
      logic       b_zero;
      logic       div_done;
   } status_type;

endpackage

// ===== rtl/core/sme_div.sv =====
// ----------------------------------------------------------------------------
// sme_div
// Iterative signed divider. Restoring division on magnitudes, one quotient
// bit per cycle, with the signs of quotient and remainder applied at the end.
// ----------------------------------------------------------------------------
module sme_div
   import sme_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type dividend,
   input  word_type divisor,
   output logic     done,
   output word_type quotient,
   output word_type remainder
);

   localparam int CNT_W = $clog2(WORD_W + 1);

   logic             active_ff, active_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   word_type         rem_ff, rem_in;
   word_type         quo_ff, quo_in;
   word_type         dvs_ff, dvs_in;
   logic             neg_q_ff, neg_q_in;
   logic             neg_r_ff, neg_r_in;

   logic [WORD_W:0]  shifted;
   logic [WORD_W:0]  diff;

   // One restoring step: shift in the next dividend bit, try the subtract
   always_comb begin
      shifted   = {rem_ff, quo_ff[WORD_W-1]};
      diff      = shifted - {1'b0, dvs_ff};
      active_in = active_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      dvs_in    = dvs_ff;
      neg_q_in  = neg_q_ff;
      neg_r_in  = neg_r_ff;
      if (start) begin
         active_in = 1'b1;
         count_in  = CNT_W'(WORD_W);
         rem_in    = '0;
         quo_in    = dividend[WORD_W-1] ? (-dividend) : dividend;
         dvs_in    = divisor[WORD_W-1] ? (-divisor) : divisor;
         neg_q_in  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
         neg_r_in  = dividend[WORD_W-1];
      end else if (active_ff) begin
         if (!diff[WORD_W]) begin
            rem_in = diff[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   // Hold control state under reset, payload free-running
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         count_ff  <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         count_ff  <= count_in;
      end
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      dvs_ff   <= dvs_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
   end

   // Apply signs; the most negative word over -1 wraps back to itself
   assign done      = done_ff;
   assign quotient  = neg_q_ff ? (-quo_ff) : quo_ff;
   assign remainder = neg_r_ff ? (-rem_ff) : rem_ff;

endmodule

// ===== rtl/core/sme_dpath.sv =====
// ----------------------------------------------------------------------------
// sme_dpath
// Datapath of the stack machine: operand stack memory, variable file,
// instruction pointer, run flag, error register, ALU, divider and the
// response register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module sme_dpath
   import sme_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [4:0]           req_opcode,
   input  logic [WORD_W-1:0]    req_immediate,
   input  logic [VAR_IDX_W-1:0] req_variable_index,
   input  logic [IP_W-1:0]      req_jump_target,
   input  logic [WORD_W-1:0]    req_read_value,
   output logic                 rsp_write_valid,
   output logic [WORD_W-1:0]    rsp_write_value,
   output logic [IP_W-1:0]      rsp_next_address,
   output logic                 rsp_running,
   output logic [1:0]           rsp_error_code
);

   localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W  = $clog2(STACK_DEPTH);

   // Latched transaction
   logic [4:0]           opcode_ff;
   word_type             imm_ff;
   logic [VAR_IDX_W-1:0] vidx_ff;
   logic [IP_W-1:0]      target_ff;
   word_type             rval_ff;

   // Architectural and step state
   logic                 executed_ff, executed_in;
   logic                 run_ff, run_in;
   err_type              err_ff, err_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;
   logic [IP_W-1:0]      ip_ff, ip_in;
   logic                 pop_hit_ff, pop_hit_in;
   word_type             opa_ff, opa_in;
   word_type             opb_ff, opb_in;
   word_type             result_ff, result_in;
   logic                 take_ff, take_in;
   logic                 wvalid_ff, wvalid_in;
   word_type             wvalue_ff, wvalue_in;
   word_type             var_ff [VAR_COUNT];
   logic                 var_we;

   // Response register
   logic                 rsp_wvalid_ff;
   word_type             rsp_wvalue_ff;
   logic [IP_W-1:0]      rsp_next_ff;
   logic                 rsp_run_ff;
   err_type              rsp_err_ff;

   // Stack memory
   word_type             stack_mem [STACK_DEPTH];
   word_type             rd_data_ff;
   logic                 mem_re;
   logic                 mem_we;
   logic [DEPTH_W-1:0]   depth_m1;
   logic [ADDR_W-1:0]    pop_addr;
   logic [ADDR_W-1:0]    push_addr;
   logic                 stack_empty;
   logic                 stack_full;
   word_type             popped;

   // Divider and ALU
   logic                 div_done;
   word_type             div_q;
   word_type             div_r;
   word_type             alu_out;
   logic [IP_W-1:0]      ip_next;

   sme_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (opa_ff),
      .divisor   (opb_ff),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign depth_m1    = depth_ff - DEPTH_W'(1);
   assign pop_addr    = depth_m1[ADDR_W-1:0];
   assign push_addr   = depth_ff[ADDR_W-1:0];
   assign stack_empty = (depth_ff == '0);
   assign stack_full  = (depth_ff >= DEPTH_W'(STACK_DEPTH));
   assign popped      = pop_hit_ff ? rd_data_ff : '0;
   assign mem_re      = cmd.pop && !stack_empty;
   assign mem_we      = cmd.push && !stack_full;

   // Decode how many pops and whether a push follows
   always_comb begin
      status.pop_count  = 2'd0;
      status.needs_push = 1'b0;
      status.div_op     = 1'b0;
      unique case (opcode_ff) inside
         OP_CONST, OP_PUSHVAR, OP_READ: begin
            status.needs_push = 1'b1;
         end
         OP_POPVAR, OP_WRITE, OP_JT, OP_JF: begin
            status.pop_count = 2'd1;
         end
         OP_ADD, OP_SUB, OP_MUL, OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE,
         OP_OR, OP_AND: begin
            status.pop_count  = 2'd2;
            status.needs_push = 1'b1;
         end
         OP_DIV, OP_MOD: begin
            status.pop_count  = 2'd2;
            status.needs_push = 1'b1;
            status.div_op     = 1'b1;
         end
         default: begin
         end
      endcase
      status.running  = run_ff;
      status.b_zero   = (opb_ff == '0);
      status.div_done = div_done;
   end

   // Binary operations other than divide
   always_comb begin
      unique case (opcode_ff) inside
         OP_ADD:  alu_out = opa_ff + opb_ff;
         OP_SUB:  alu_out = opa_ff - opb_ff;
         OP_MUL:  alu_out = opa_ff * opb_ff;
         OP_EQ:   alu_out = WORD_W'(opa_ff == opb_ff);
         OP_NE:   alu_out = WORD_W'(opa_ff != opb_ff);
         OP_LT:   alu_out = WORD_W'($signed(opa_ff) <  $signed(opb_ff));
         OP_LE:   alu_out = WORD_W'($signed(opa_ff) <= $signed(opb_ff));
         OP_GT:   alu_out = WORD_W'($signed(opa_ff) >  $signed(opb_ff));
         OP_GE:   alu_out = WORD_W'($signed(opa_ff) >= $signed(opb_ff));
         OP_OR:   alu_out = WORD_W'((opa_ff != '0) || (opb_ff != '0));
         OP_AND:  alu_out = WORD_W'((opa_ff != '0) && (opb_ff != '0));
         default: alu_out = '0;
      endcase
   end

   assign ip_next = take_ff ? target_ff : (ip_ff + IP_W'(1));

   // Next values of the step state
   always_comb begin
      executed_in = executed_ff;
      run_in      = run_ff;
      err_in      = err_ff;
      depth_in    = depth_ff;
      ip_in       = ip_ff;
      pop_hit_in  = pop_hit_ff;
      opa_in      = opa_ff;
      opb_in      = opb_ff;
      result_in   = result_ff;
      take_in     = take_ff;
      wvalid_in   = wvalid_ff;
      wvalue_in   = wvalue_ff;
      var_we      = 1'b0;

      // Open a new transaction
      if (cmd.start) begin
         executed_in = run_ff;
         err_in      = ERR_NONE;
         take_in     = 1'b0;
         wvalid_in   = 1'b0;
         wvalue_in   = '0;
      end

      // Pop; an empty stack yields zero and halts
      if (cmd.pop) begin
         if (stack_empty) begin
            pop_hit_in = 1'b0;
            run_in     = 1'b0;
            if (err_ff == ERR_NONE) begin
               err_in = ERR_UNDERFLOW;
            end
         end else begin
            pop_hit_in = 1'b1;
            depth_in   = depth_m1;
         end
      end

      if (cmd.cap_b) begin
         opb_in = popped;
      end
      if (cmd.cap_a) begin
         opa_in = popped;
      end

      // Execute
      if (cmd.exec) begin
         unique case (opcode_ff) inside
            OP_HALT:    run_in    = 1'b0;
            OP_CONST:   result_in = imm_ff;
            OP_READ:    result_in = rval_ff;
            OP_PUSHVAR: result_in = var_ff[vidx_ff];
            OP_POPVAR:  var_we    = 1'b1;
            OP_WRITE: begin
               wvalid_in = 1'b1;
               wvalue_in = opb_ff;
            end
            OP_JMP:     take_in   = 1'b1;
            OP_JT:      take_in   = (opb_ff != '0);
            OP_JF:      take_in   = (opb_ff == '0);
            OP_DIV, OP_MOD: begin
               // only reached here with a zero divisor
               result_in = '0;
               run_in    = 1'b0;
               if (err_ff == ERR_NONE) begin
                  err_in = ERR_DIVZERO;
               end
            end
            default:    result_in = alu_out;
         endcase
      end

      if (cmd.div_cap) begin
         result_in = (opcode_ff == OP_DIV) ? div_q : div_r;
      end

      // Push; a full stack drops the word and halts
      if (cmd.push) begin
         if (stack_full) begin
            run_in = 1'b0;
            if (err_ff == ERR_NONE) begin
               err_in = ERR_OVERFLOW;
            end
         end else begin
            depth_in = depth_ff + DEPTH_W'(1);
         end
      end

      // Advance the pointer on executed steps only
      if (cmd.finish && executed_ff) begin
         ip_in = ip_next;
      end
   end

   // Control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         executed_ff <= 1'b0;
         run_ff      <= 1'b1;
         err_ff      <= ERR_NONE;
         depth_ff    <= '0;
         ip_ff       <= '0;
         for (int i = 0; i < VAR_COUNT; i++) begin
            var_ff[i] <= '0;
         end
      end else begin
         executed_ff <= executed_in;
         run_ff      <= run_in;
         err_ff      <= err_in;
         depth_ff    <= depth_in;
         ip_ff       <= ip_in;
         if (var_we) begin
            var_ff[vidx_ff] <= opb_ff;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         opcode_ff <= req_opcode;
         imm_ff    <= req_immediate;
         vidx_ff   <= req_variable_index;
         target_ff <= req_jump_target;
         rval_ff   <= req_read_value;
      end
      pop_hit_ff <= pop_hit_in;
      opa_ff     <= opa_in;
      opb_ff     <= opb_in;
      result_ff  <= result_in;
      take_ff    <= take_in;
      wvalid_ff  <= wvalid_in;
      wvalue_ff  <= wvalue_in;
   end

   // Operand stack
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stack_mem[push_addr] <= result_ff;
      end
      if (mem_re) begin
         rd_data_ff <= stack_mem[pop_addr];
      end
   end

   // Load the response; a halted step reports the held pointer only
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         if (executed_ff) begin
            rsp_wvalid_ff <= wvalid_ff;
            rsp_wvalue_ff <= wvalue_ff;
            rsp_next_ff   <= ip_next;
            rsp_run_ff    <= run_ff;
            rsp_err_ff    <= err_ff;
         end else begin
            rsp_wvalid_ff <= 1'b0;
            rsp_wvalue_ff <= '0;
            rsp_next_ff   <= ip_ff;
            rsp_run_ff    <= 1'b0;
            rsp_err_ff    <= ERR_NONE;
         end
      end
   end

   assign rsp_write_valid  = rsp_wvalid_ff;
   assign rsp_write_value  = rsp_wvalue_ff;
   assign rsp_next_address = rsp_next_ff;
   assign rsp_running      = rsp_run_ff;
   assign rsp_error_code   = rsp_err_ff;

endmodule

// ===== rtl/core/sme_ctrl.sv =====
// ----------------------------------------------------------------------------
// sme_ctrl
// Controller of the stack machine: sequences decode, pops, execute, divide,
// push and commit for each transaction, and owns the response valid flag.
// ----------------------------------------------------------------------------
module sme_ctrl
   import sme_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      div_needed;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign div_needed = status.div_op && !status.b_zero;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!status.running) begin
               state_in = S_FINISH;
            end else if (status.pop_count != 2'd0) begin
               state_in = S_POPB;
            end else begin
               state_in = S_EXEC;
            end
         end
         S_POPB: begin
            state_in = (status.pop_count == 2'd2) ? S_POPA : S_EXEC;
         end
         S_POPA: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (div_needed) begin
               state_in = S_DIV;
            end else if (status.needs_push) begin
               state_in = S_PUSH;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_DIV: begin
            if (status.div_done) begin
               state_in = S_PUSH;
            end
         end
         S_PUSH: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.start = req_valid;
         end
         S_DECODE: begin
            cmd.pop = status.running && (status.pop_count != 2'd0);
         end
         S_POPB: begin
            cmd.cap_b = 1'b1;
            cmd.pop   = (status.pop_count == 2'd2);
         end
         S_POPA: begin
            cmd.cap_a = 1'b1;
         end
         S_EXEC: begin
            cmd.exec      = !div_needed;
            cmd.div_start = div_needed;
         end
         S_DIV: begin
            cmd.div_cap = status.div_done;
         end
         S_PUSH: begin
            cmd.push = 1'b1;
         end
         S_FINISH: begin
            cmd.finish = out_free;
         end
         default: begin
         end
      endcase
   end

   // Hold the response until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/stack_machine_execute.sv =====
// ----------------------------------------------------------------------------
// stack_machine_execute
// Executes one decoded stack machine instruction per transaction and returns
// one response with the write output, next pointer, run flag and error code.
// ----------------------------------------------------------------------------
// One transaction is in flight at a time. After the accept, an instruction
// passes decode, up to two pops, execute, the divider for div and mod with a
// nonzero divisor, a push if it has a result, and commit; a halted machine
// goes from decode to commit. Halt, jmp and the no-op codes touch no stack;
// const, pushvar and read push once, popvar, write, jt and jf pop once, and
// binary operations pop twice and push. The iterative divider, one quotient
// bit per cycle, makes div and mod the slowest. The commit step waits while
// the previous response is stalled. Each pop reads the stack memory through
// its registered read port, one word per cycle. A new transaction is taken
// while the previous response still waits in the output register. The stack
// memory needs no clearing after reset; the variable file clears at reset.
module stack_machine_execute
   import sme_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEFAULT
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [4:0]           req_opcode,
   input  logic [WORD_W-1:0]    req_immediate,
   input  logic [VAR_IDX_W-1:0] req_variable_index,
   input  logic [IP_W-1:0]      req_jump_target,
   input  logic [WORD_W-1:0]    req_read_value,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_write_valid,
   output logic [WORD_W-1:0]    rsp_write_value,
   output logic [IP_W-1:0]      rsp_next_address,
   output logic                 rsp_running,
   output logic [1:0]           rsp_error_code
);

   cmd_type    cmd;
   status_type status;

   sme_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sme_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_opcode         (req_opcode),
      .req_immediate      (req_immediate),
      .req_variable_index (req_variable_index),
      .req_jump_target    (req_jump_target),
      .req_read_value     (req_read_value),
      .rsp_write_valid    (rsp_write_valid),
      .rsp_write_value    (rsp_write_value),
      .rsp_next_address   (rsp_next_address),
      .rsp_running        (rsp_running),
      .rsp_error_code     (rsp_error_code)
   );

endmodule

// ===== rtl/core/sme_checker.sv =====
// ----------------------------------------------------------------------------
// sme_checker
// Port-level checks of the stack machine execution unit, bound to the top.
// ----------------------------------------------------------------------------
module sme_checker
   import sme_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input logic                 rsp_write_valid,
   input logic [WORD_W-1:0]    rsp_write_value,
   input logic [IP_W-1:0]      rsp_next_address,
   input logic                 rsp_running,
   input logic [1:0]           rsp_error_code
);

   // No response right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // An accepted transaction keeps the input side busy in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second transaction accepted while one is in flight");

   // A stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_next_address)
         && $stable(rsp_error_code) && $stable(rsp_write_value)))
      else $error("stalled response changed");

   // Any error halts the machine
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_error_code != ERR_NONE)) |-> !rsp_running)
      else $error("error reported while still running");

   // Write value is zero unless a write executed
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_write_valid) |-> (rsp_write_value == '0))
      else $error("write value without write");

endmodule

bind stack_machine_execute sme_checker u_sme_checker (.*);
